FILE: rtl/core/hbcm_pkg.sv
// Package: types and constants for the hashed buffer cache manager.
package hbcm_pkg;
   localparam int NUM_BUFFERS_DEF = 32;
   localparam int NUM_BUCKETS_DEF = 13;
   localparam logic [7:0] REFS_MAX = 8'd255;

   typedef enum logic [1:0] {
      REQ_GET     = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_PIN     = 2'd2,
      REQ_UNPIN   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HIT_SCAN,
      S_VIC_SCAN,
      S_SLOT_RD,
      S_SLOT_ACT,
      S_RANK_PASS,
      S_RESP
   } fsm_type;
endpackage

FILE: rtl/core/hbcm_if.sv
// Interfaces: request and response channels.
interface hbcm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  device_id;
   logic [31:0] block_number;
   logic [4:0]  buffer_slot;
   modport source (output valid, req_type, device_id, block_number, buffer_slot,
                   input ready);
   modport sink (input valid, req_type, device_id, block_number, buffer_slot,
                 output ready);
endinterface

interface hbcm_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] slot_out;
   logic       hit;
   logic       needs_read;
   logic [1:0] status;
   modport source (output valid, slot_out, hit, needs_read, status, input ready);
   modport sink (input valid, slot_out, hit, needs_read, status, output ready);
endinterface

FILE: rtl/core/hashed_buffer_cache_manager.sv
// Top level: hashed buffer cache manager with tag memory and sequencer.
//  channel | dir | handshake       | payload
//  req     | in  | valid/ready     | req_type, device_id, block_number, buffer_slot
//  rsp     | out | valid/ready     | slot_out, hit, needs_read, status
// Get: hit scan, then a victim scan on a miss, then a rank pass on a fill.
// Release/pin/unpin: slot read, then slot update, plus a rank pass when a release frees the buffer.
// The single-port-read tag memory sets the scan length; one entry is read per cycle.
// Reset (synchronous) starts a clear of every tag entry, during which no request is taken.
// The response holds in its register until taken; the next request waits for it.
module hashed_buffer_cache_manager
   import hbcm_pkg::*;
#(
   parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
   input logic clock,
   input logic reset,
   hbcm_req_if.sink   req,
   hbcm_rsp_if.source rsp
);
   localparam int AW = $clog2(NUM_BUFFERS);
   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int CW = AW + 1;
   // residues of byte weights, and reciprocal for the last small reduction
   localparam int HC1 = 256 % NUM_BUCKETS;
   localparam int HC2 = 65536 % NUM_BUCKETS;
   localparam int HC3 = 16777216 % NUM_BUCKETS;
   localparam int HM  = (8192 + NUM_BUCKETS - 1) / NUM_BUCKETS;

   typedef struct packed {
      logic [7:0]    dev;
      logic [31:0]   blk;
      logic [7:0]    refs;
      logic          loaded;
      logic [BW-1:0] bucket;
      logic [AW-1:0] rank;
   } entry_type;

   entry_type mem [NUM_BUFFERS];
   entry_type rd_ff;

   fsm_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;

   logic [1:0]  op_ff, op_in;
   logic [7:0]  dev_ff, dev_in;
   logic [31:0] blk_ff, blk_in;
   logic [4:0]  slot_ff, slot_in;
   logic [BW-1:0] hash_ff, hash_in;
   logic [13:0]   hfold_ff, hfold_in;

   logic          found_ff, found_in;
   logic [AW-1:0] best_ff, best_in;
   logic [AW-1:0] brank_ff, brank_in;
   logic [BW-1:0] bbuck_ff, bbuck_in;
   logic [AW-1:0] pivot_ff, pivot_in;

   logic       vld_ff, vld_in;
   logic [4:0] ro_slot_ff, ro_slot_in;
   logic       ro_hit_ff, ro_hit_in;
   logic       ro_rd_ff, ro_rd_in;
   logic [1:0] ro_st_ff, ro_st_in;

   logic          re;
   logic [AW-1:0] raddr;
   logic          we;
   logic [AW-1:0] waddr;
   entry_type     wdata;

   logic [AW-1:0] prev_idx;
   logic [13:0]   hsum1;
   logic [10:0]   hsum2;
   logic [8:0]    hsum3;
   logic [22:0]   hprod;
   logic [8:0]    hquo;
   logic [8:0]    hrem;

   assign prev_idx = AW'(cnt_ff - CW'(1));

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_ff <= mem[raddr];
   end

   // block mod NUM_BUCKETS in three steps: fold bytes by their residues twice,
   // then finish with a small reciprocal multiply
   assign hsum1 = 14'(blk_ff[7:0]) + 14'(blk_ff[15:8]) * 14'(HC1) +
                  14'(blk_ff[23:16]) * 14'(HC2) + 14'(blk_ff[31:24]) * 14'(HC3);
   assign hsum2 = 11'(hfold_ff[7:0]) + 11'(hfold_ff[13:8]) * 11'(HC1);
   assign hsum3 = 9'(hsum2[7:0]) + 9'(hsum2[10:8]) * 9'(HC1);
   assign hprod = 23'(hfold_ff[8:0]) * 23'(HM);
   assign hquo  = hprod[21:13];
   assign hrem  = hfold_ff[8:0] - hquo * 9'(NUM_BUCKETS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
         vld_ff     <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_idx_ff <= clr_idx_in;
         vld_ff     <= vld_in;
         cnt_ff     <= cnt_in;
      end
      op_ff <= op_in; dev_ff <= dev_in; blk_ff <= blk_in; slot_ff <= slot_in;
      hash_ff <= hash_in; hfold_ff <= hfold_in; found_ff <= found_in; best_ff <= best_in;
      brank_ff <= brank_in; bbuck_ff <= bbuck_in; pivot_ff <= pivot_in;
      ro_slot_ff <= ro_slot_in; ro_hit_ff <= ro_hit_in;
      ro_rd_ff <= ro_rd_in; ro_st_ff <= ro_st_in;
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; clr_in = clr_ff; clr_idx_in = clr_idx_ff;
      op_in = op_ff; dev_in = dev_ff; blk_in = blk_ff; slot_in = slot_ff;
      hash_in = hash_ff; found_in = found_ff; best_in = best_ff; brank_in = brank_ff;
      bbuck_in = bbuck_ff; pivot_in = pivot_ff; hfold_in = hfold_ff;
      vld_in = vld_ff; ro_slot_in = ro_slot_ff; ro_hit_in = ro_hit_ff;
      ro_rd_in = ro_rd_ff; ro_st_in = ro_st_ff;
      re = 1'b0; raddr = '0; we = 1'b0; waddr = '0; wdata = rd_ff;
      req.ready = 1'b0;

      if (vld_ff && rsp.ready) vld_in = 1'b0;

      if (clr_ff) begin
         we = 1'b1; waddr = clr_idx_ff;
         wdata = '0; wdata.rank = clr_idx_ff;
         clr_idx_in = clr_idx_ff + AW'(1);
         if (32'(clr_idx_ff) == NUM_BUFFERS - 1) clr_in = 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               req.ready = !vld_ff;
               if (req.valid && !vld_ff) begin
                  op_in = req.req_type; dev_in = req.device_id;
                  blk_in = req.block_number; slot_in = req.buffer_slot;
                  found_in = 1'b0; cnt_in = '0; hash_in = '0;
                  if (req_kind_type'(req.req_type) == REQ_GET) begin
                     state_in = S_HIT_SCAN;
                  end else if (32'(req.buffer_slot) >= NUM_BUFFERS) begin
                     ro_slot_in = req.buffer_slot; ro_hit_in = 1'b0; ro_rd_in = 1'b0;
                     ro_st_in = ST_NO_FREE; vld_in = 1'b1;
                  end else begin
                     state_in = S_SLOT_RD;
                  end
               end
            end
            S_HIT_SCAN: begin
               if (cnt_ff == CW'(0)) hfold_in = hsum1;
               else if (cnt_ff == CW'(1)) hfold_in = 14'(hsum3);
               else if (cnt_ff == CW'(2)) hash_in = BW'(hrem);
               if (32'(cnt_ff) < NUM_BUFFERS) begin
                  re = 1'b1; raddr = AW'(cnt_ff);
               end
               if (cnt_ff != '0) begin
                  if (rd_ff.dev == dev_ff && rd_ff.blk == blk_ff &&
                      (!found_ff || rd_ff.rank > brank_ff)) begin
                     found_in = 1'b1; best_in = prev_idx; brank_in = rd_ff.rank;
                  end
               end
               cnt_in = cnt_ff + CW'(1);
               if (32'(cnt_ff) == NUM_BUFFERS) begin
                  cnt_in = '0;
                  if (found_in) begin
                     re = 1'b1; raddr = best_in;
                     state_in = S_SLOT_ACT;
                     slot_in = 5'(best_in);
                  end else begin
                     found_in = 1'b0;
                     state_in = S_VIC_SCAN;
                  end
               end
            end
            S_VIC_SCAN: begin
               if (32'(cnt_ff) < NUM_BUFFERS) begin
                  re = 1'b1; raddr = AW'(cnt_ff);
               end
               if (cnt_ff != '0) begin
                  if (rd_ff.refs == 8'd0 &&
                      (!found_ff || rd_ff.bucket < bbuck_ff ||
                       (rd_ff.bucket == bbuck_ff && rd_ff.rank < brank_ff))) begin
                     found_in = 1'b1; best_in = prev_idx;
                     brank_in = rd_ff.rank; bbuck_in = rd_ff.bucket;
                  end
               end
               cnt_in = cnt_ff + CW'(1);
               if (32'(cnt_ff) == NUM_BUFFERS) begin
                  cnt_in = '0;
                  if (!found_in) begin
                     ro_slot_in = '0; ro_hit_in = 1'b0; ro_rd_in = 1'b0;
                     ro_st_in = ST_NO_FREE; vld_in = 1'b1; state_in = S_IDLE;
                  end else begin
                     we = 1'b1; waddr = best_in;
                     wdata.dev = dev_ff; wdata.blk = blk_ff; wdata.refs = 8'd1;
                     wdata.loaded = 1'b1; wdata.bucket = hash_ff;
                     wdata.rank = AW'(NUM_BUFFERS - 1);
                     pivot_in = brank_in; slot_in = 5'(best_in);
                     ro_slot_in = 5'(best_in); ro_hit_in = 1'b0; ro_rd_in = 1'b1;
                     ro_st_in = ST_OK;
                     state_in = S_RANK_PASS;
                  end
               end
            end
            S_SLOT_RD: begin
               re = 1'b1; raddr = AW'(slot_ff);
               state_in = S_SLOT_ACT;
            end
            S_SLOT_ACT: begin
               ro_slot_in = slot_ff; ro_hit_in = 1'b0; ro_rd_in = 1'b0;
               state_in = S_IDLE;
               vld_in = 1'b1;
               waddr = AW'(slot_ff);
               if (req_kind_type'(op_ff) == REQ_GET || req_kind_type'(op_ff) == REQ_PIN) begin
                  ro_hit_in = (req_kind_type'(op_ff) == REQ_GET);
                  if (rd_ff.refs == REFS_MAX) begin
                     ro_st_in = ST_SATURATED;
                  end else begin
                     ro_st_in = ST_OK; we = 1'b1;
                     wdata.refs = rd_ff.refs + 8'd1;
                     if (req_kind_type'(op_ff) == REQ_GET) begin
                        ro_rd_in = !rd_ff.loaded; wdata.loaded = 1'b1;
                     end
                  end
               end else if (rd_ff.refs == 8'd0) begin
                  ro_st_in = ST_UNDERFLOW;
               end else begin
                  ro_st_in = ST_OK; we = 1'b1;
                  wdata.refs = rd_ff.refs - 8'd1;
                  if (req_kind_type'(op_ff) == REQ_RELEASE && rd_ff.refs == 8'd1) begin
                     wdata.rank = AW'(NUM_BUFFERS - 1);
                     pivot_in = rd_ff.rank; cnt_in = '0;
                     vld_in = 1'b0; state_in = S_RANK_PASS;
                  end
               end
            end
            S_RANK_PASS: begin
               // read i, then decrement rank if above pivot; skip the acted slot
               if (32'(cnt_ff) < NUM_BUFFERS) begin
                  re = 1'b1; raddr = AW'(cnt_ff);
               end
               if (cnt_ff != '0 && prev_idx != AW'(slot_ff) && rd_ff.rank > pivot_ff) begin
                  we = 1'b1; waddr = prev_idx;
                  wdata.rank = rd_ff.rank - AW'(1);
               end
               cnt_in = cnt_ff + CW'(1);
               if (32'(cnt_ff) == NUM_BUFFERS) begin
                  cnt_in = '0; vld_in = 1'b1; state_in = S_IDLE;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   assign rsp.valid      = vld_ff;
   assign rsp.slot_out   = ro_slot_ff;
   assign rsp.hit        = ro_hit_ff;
   assign rsp.needs_read = ro_rd_ff;
   assign rsp.status     = ro_st_ff;

`ifndef SYNTH
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !(req.valid && req.ready)) else $error("request taken during clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !rsp.ready) |=> vld_ff) else $error("response dropped");
   a_idle_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> (state_ff == S_IDLE && !vld_ff))
      else $error("accept while busy");
   a_rank_pass_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RANK_PASS && we) |-> (waddr != AW'(slot_ff)))
      else $error("rank pass touched acted slot");
`endif
endmodule

FILE: tb/hashed_buffer_cache_manager_tb.sv
// Testbench: hashed buffer cache manager, directed table then predictor-checked random traffic.
module hashed_buffer_cache_manager_tb
   import hbcm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBUF = NUM_BUFFERS_DEF;
   localparam int NBKT = NUM_BUCKETS_DEF;
   localparam int IDLE_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 1730;
   localparam int SAT_REFS = 256;

   typedef struct {
      req_kind_type kind;
      logic [7:0]   dev;
      logic [31:0]  blk;
      logic [4:0]   slot;
   } cache_req_type;

   typedef struct {
      logic [4:0] slot;
      logic       hit;
      logic       rd;
      status_type st;
   } cache_rsp_type;

   typedef struct {
      cache_req_type rq;
      bit            typed;
      cache_rsp_type want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hbcm_req_if req ();
   hbcm_rsp_if rsp ();

   hashed_buffer_cache_manager uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted tag state
   logic [7:0]  tag_dev [NBUF];
   logic [31:0] tag_blk [NBUF];
   int          tag_refs [NBUF];
   bit          tag_loaded [NBUF];
   int          tag_bucket [NBUF];
   int          lru_rank [NBUF];

   cache_rsp_type pending_rsp [$];
   cache_req_type script [$];
   logic [31:0]   blk_pool [24];
   int            errors = 0;
   int            sent = 0;
   bit            req_taken = 0;
   bit            cur_typed = 0;
   cache_rsp_type cur_want;
   bit            hold_off = 0;
   bit            sat_planned = 0;
   int            idle_cycles = 0;

   task automatic report(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void bump_newest(int s);
      int r;
      r = lru_rank[s];
      for (int i = 0; i < NBUF; i++)
         if (lru_rank[i] > r) lru_rank[i]--;
      lru_rank[s] = NBUF - 1;
   endfunction

   function automatic cache_rsp_type lookup_tags(cache_req_type q);
      cache_rsp_type o;
      int best;
      best = -1;
      o = '{slot: q.slot, hit: 1'b0, rd: 1'b0, st: ST_OK};
      if (q.kind == REQ_GET) begin
         for (int i = 0; i < NBUF; i++)
            if (tag_dev[i] == q.dev && tag_blk[i] == q.blk &&
                (best < 0 || lru_rank[i] > lru_rank[best])) best = i;
         if (best >= 0) begin
            o.slot = best[4:0];
            o.hit = 1'b1;
            if (tag_refs[best] >= REFS_MAX) begin
               o.st = ST_SATURATED;
            end else begin
               tag_refs[best]++;
               o.rd = !tag_loaded[best];
               tag_loaded[best] = 1;
            end
            return o;
         end
         for (int i = 0; i < NBUF; i++) begin
            if (tag_refs[i] != 0) continue;
            if (best < 0 || tag_bucket[i] < tag_bucket[best] ||
                (tag_bucket[i] == tag_bucket[best] && lru_rank[i] < lru_rank[best])) best = i;
         end
         if (best < 0) begin
            o.slot = '0;
            o.st = ST_NO_FREE;
            return o;
         end
         tag_dev[best] = q.dev;
         tag_blk[best] = q.blk;
         tag_refs[best] = 1;
         tag_loaded[best] = 1;
         tag_bucket[best] = q.blk % NBKT;
         bump_newest(best);
         o.slot = best[4:0];
         o.rd = 1'b1;
         return o;
      end
      if (q.slot >= NBUF) begin
         o.st = ST_NO_FREE;
         return o;
      end
      if (q.kind == REQ_PIN) begin
         if (tag_refs[q.slot] >= REFS_MAX) o.st = ST_SATURATED;
         else tag_refs[q.slot]++;
         return o;
      end
      if (tag_refs[q.slot] == 0) begin
         o.st = ST_UNDERFLOW;
         return o;
      end
      tag_refs[q.slot]--;
      if (q.kind == REQ_RELEASE && tag_refs[q.slot] == 0) bump_newest(q.slot);
      return o;
   endfunction

   // request side: predict on every transfer
   always @(posedge clock) begin
      cache_rsp_type p;
      if (!reset && req.valid && req.ready) begin
         p = lookup_tags('{kind: req_kind_type'(req.req_type), dev: req.device_id,
                           blk: req.block_number, slot: req.buffer_slot});
         pending_rsp.push_back(cur_typed ? cur_want : p);
         req_taken = 1;
      end
   end

   // response side: compare against oldest expectation
   always @(posedge clock) begin
      cache_rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsp.size() == 0) begin
            report("unexpected response slot", rsp.slot_out, -1);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp.slot_out !== e.slot) report("slot_out", rsp.slot_out, e.slot);
            if (rsp.hit !== e.hit) report("hit", rsp.hit, e.hit);
            if (rsp.needs_read !== e.rd) report("needs_read", rsp.needs_read, e.rd);
            if (rsp.status !== e.st) report("status", rsp.status, e.st);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("hashed_buffer_cache_manager_tb: done, errors");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off
   initial begin
      int r;
      rsp.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            hold_off = 0;
            rsp.ready = 1'b0;
            repeat (400) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp.ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp.ready = 1'b0;
            repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(20, 60)) @(negedge clock);
         end
      end
   end

   task automatic send(cache_req_type q, bit typed, cache_rsp_type want);
      int g;
      g = ($urandom_range(0, 99) < 50) ? 0 :
          ($urandom_range(0, 99) < 92 ? $urandom_range(1, 3) : $urandom_range(15, 50));
      if (g > 0) begin
         req.valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req.req_type = q.kind;
      req.device_id = q.dev;
      req.block_number = q.blk;
      req.buffer_slot = q.slot;
      cur_typed = typed;
      cur_want = want;
      req.valid = 1'b1;
      req_taken = 0;
      do @(negedge clock); while (!req_taken);
      sent++;
      if (sent == 300) hold_off = 1;
   endtask

   function automatic cache_req_type held_slot_req(req_kind_type k);
      int s;
      s = $urandom_range(0, NBUF - 1);
      for (int i = 0; i < NBUF; i++)
         if (tag_refs[(s + i) % NBUF] > 0) begin
            s = (s + i) % NBUF;
            break;
         end
      return '{kind: k, dev: 8'($urandom), blk: $urandom, slot: s[4:0]};
   endfunction

   function automatic cache_req_type pool_get();
      logic [7:0] d;
      d = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
      if ($urandom_range(0, 19) == 0) d = 8'hff;
      return '{kind: REQ_GET, dev: d, blk: blk_pool[$urandom_range(0, 23)],
               slot: 5'($urandom)};
   endfunction

   function automatic void plan_next();
      int r;
      int s;
      cache_req_type q;
      r = $urandom_range(0, 999);
      if (sent > 500 && !sat_planned && script.size() == 0) begin
         // drive one tagged buffer to saturation via pins, then hit it with a get
         sat_planned = 1;
         q = held_slot_req(REQ_PIN);
         s = q.slot;
         repeat (SAT_REFS) script.push_back('{REQ_PIN, 8'h0, 32'h0, s[4:0]});
         script.push_back('{REQ_GET, tag_dev[s], tag_blk[s], 5'h0});
         repeat (SAT_REFS + 2) script.push_back('{REQ_UNPIN, 8'h0, 32'h0, s[4:0]});
      end else if (r < 15) begin
         // exhaust the free list
         repeat (NBUF + 3) script.push_back('{REQ_GET, 8'($urandom), $urandom, 5'h0});
         for (int i = 0; i < NBUF; i++)
            repeat (3) script.push_back('{REQ_RELEASE, 8'h0, 32'h0, i[4:0]});
      end else if (r < 480) begin
         script.push_back(pool_get());
      end else if (r < 800) begin
         script.push_back(held_slot_req(REQ_RELEASE));
      end else if (r < 880) begin
         script.push_back(held_slot_req(REQ_PIN));
      end else if (r < 950) begin
         script.push_back(held_slot_req(REQ_UNPIN));
      end else begin
         script.push_back('{req_kind_type'($urandom_range(0, 3)), 8'($urandom), $urandom,
                            5'($urandom)});
      end
   endfunction

   initial begin
      table_row_type rows [$];
      cache_rsp_type none;
      none = '{5'h0, 1'b0, 1'b0, ST_OK};
      req.valid = 1'b0;
      req.req_type = REQ_GET;
      req.device_id = '0;
      req.block_number = '0;
      req.buffer_slot = '0;
      for (int i = 0; i < NBUF; i++) begin
         tag_dev[i] = '0;
         tag_blk[i] = '0;
         tag_refs[i] = 0;
         tag_loaded[i] = 0;
         tag_bucket[i] = 0;
         lru_rank[i] = i;
      end
      foreach (blk_pool[i]) blk_pool[i] = $urandom;
      blk_pool[0] = 32'h0;
      blk_pool[1] = 32'hffff_ffff;
      blk_pool[2] = 32'd12;
      blk_pool[3] = 32'd13;

      rows.push_back('{'{REQ_GET, 8'h00, 32'h0, 5'd0}, 1, '{5'd31, 1'b1, 1'b1, ST_OK}});
      rows.push_back('{'{REQ_RELEASE, 8'h00, 32'h0, 5'd31}, 1, '{5'd31, 1'b0, 1'b0, ST_OK}});
      rows.push_back('{'{REQ_UNPIN, 8'h00, 32'h0, 5'd5}, 1,
                       '{5'd5, 1'b0, 1'b0, ST_UNDERFLOW}});
      rows.push_back('{'{REQ_RELEASE, 8'h00, 32'h0, 5'd5}, 1,
                       '{5'd5, 1'b0, 1'b0, ST_UNDERFLOW}});
      rows.push_back('{'{REQ_PIN, 8'h00, 32'h0, 5'd7}, 1, '{5'd7, 1'b0, 1'b0, ST_OK}});
      rows.push_back('{'{REQ_UNPIN, 8'h00, 32'h0, 5'd7}, 1, '{5'd7, 1'b0, 1'b0, ST_OK}});
      rows.push_back('{'{REQ_GET, 8'hff, 32'hffff_ffff, 5'd0}, 1,
                       '{5'd0, 1'b0, 1'b1, ST_OK}});
      rows.push_back('{'{REQ_GET, 8'hff, 32'hffff_ffff, 5'd0}, 1,
                       '{5'd0, 1'b1, 1'b0, ST_OK}});
      rows.push_back('{'{REQ_GET, 8'h01, 32'd12, 5'd0}, 0, none});
      rows.push_back('{'{REQ_GET, 8'h01, 32'd13, 5'd0}, 0, none});
      rows.push_back('{'{REQ_GET, 8'h01, 32'd25, 5'd31}, 0, none});
      rows.push_back('{'{REQ_PIN, 8'h00, 32'h0, 5'd31}, 0, none});
      rows.push_back('{'{REQ_GET, 8'h00, 32'h0, 5'd0}, 0, none});
      rows.push_back('{'{REQ_RELEASE, 8'h00, 32'h0, 5'd0}, 0, none});
      rows.push_back('{'{REQ_RELEASE, 8'h00, 32'h0, 5'd0}, 0, none});
      rows.push_back('{'{REQ_RELEASE, 8'h00, 32'h0, 5'd0}, 0, none});
      rows.push_back('{'{REQ_UNPIN, 8'h00, 32'h0, 5'd31}, 0, none});
      rows.push_back('{'{REQ_GET, 8'h01, 32'd12, 5'd0}, 0, none});
      rows.push_back('{'{REQ_RELEASE, 8'h00, 32'h0, 5'd1}, 0, none});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send(rows[i].rq, rows[i].typed, rows[i].want);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (script.size() == 0) plan_next();
         send(script.pop_front(), 0, none);
      end
      while (script.size() != 0) send(script.pop_front(), 0, none);
      req.valid = 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) $display("hashed_buffer_cache_manager_tb: done, clean");
      else $display("hashed_buffer_cache_manager_tb: done, errors");
      $finish;
   end
endmodule
